// ----- design/rowol_pkg.sv -----
// ----------------------------------------------------------------------------
// rowol_pkg: shared types for the write-record ring
// Request, response and internal command formats, queue status and the
// back-end sequencer states.
// ----------------------------------------------------------------------------
package rowol_pkg;

	localparam int HANDLE_W = 32;
	localparam int BYTES_W  = 16;
	localparam int POS_W    = 20;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_FIND = 1'b1
	} op_t;

	typedef struct packed {
		logic                req_type;
		logic [HANDLE_W-1:0] entry_handle;
		logic [BYTES_W-1:0]  entry_bytes;
		logic [POS_W-1:0]    char_position;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [HANDLE_W-1:0] hit_handle;
		logic [BYTES_W-1:0]  hit_bytes;
		logic [BYTES_W-1:0]  byte_within;
	} rsp_t;

	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] handle;
		logic [BYTES_W-1:0]  bytes;
		logic [POS_W-1:0]    pos;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_WALK = 1'b1
	} back_st_t;

endpackage

// ----- design/rowol_front.sv -----
// ----------------------------------------------------------------------------
// rowol_front: request intake
// Captures one request transaction, decodes its kind and hands it to the
// command queue as soon as the queue has room.
// ----------------------------------------------------------------------------
module rowol_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rowol_pkg::req_t    req,
	output logic               busy,
	input  rowol_pkg::q_stat_t q_stat,
	output logic               push,
	output rowol_pkg::cmd_t    push_cmd
);

	logic            fr_vld_q;
	rowol_pkg::cmd_t fr_cmd_q;
	rowol_pkg::cmd_t dec_cmd;
	logic            accept;

	always_comb begin
		dec_cmd.handle = req.entry_handle;
		dec_cmd.bytes  = req.entry_bytes;
		dec_cmd.pos    = req.char_position;
		unique case (req.req_type)
			rowol_pkg::OP_ADD:  dec_cmd.op = rowol_pkg::OP_ADD;
			rowol_pkg::OP_FIND: dec_cmd.op = rowol_pkg::OP_FIND;
			default:            dec_cmd.op = rowol_pkg::OP_ADD;
		endcase
	end

	assign busy     = fr_vld_q && q_stat.full;
	assign push     = fr_vld_q && !q_stat.full;
	assign accept   = start && !busy;
	assign push_cmd = fr_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_q <= 1'b0;
		end else if (accept) begin
			fr_vld_q <= 1'b1;
		end else if (push) begin
			fr_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_cmd_q <= dec_cmd;
		end
	end

endmodule

// ----- design/rowol_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// rowol_cmd_queue: two-entry command queue
// Decouples request intake from command execution and keeps order.
// ----------------------------------------------------------------------------
module rowol_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rowol_pkg::cmd_t    push_cmd,
	input  logic               pop,
	output rowol_pkg::cmd_t    head,
	output rowol_pkg::q_stat_t q_stat
);

	rowol_pkg::cmd_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- design/rowol_back.sv -----
// ----------------------------------------------------------------------------
// rowol_back: command execution
// Owns the record memory and ring indices. Adds are written as they are popped;
// finds stream the records out of memory one per cycle and accumulate sizes.
// ----------------------------------------------------------------------------
module rowol_back #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rowol_pkg::cmd_t    head,
	input  rowol_pkg::q_stat_t q_stat,
	output logic               pop,
	output logic               rsp_valid,
	output rowol_pkg::rsp_t    rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// Wide enough for the total size of a full ring and for any position.
	localparam int SW = (IW + rowol_pkg::BYTES_W > rowol_pkg::POS_W) ?
		IW + rowol_pkg::BYTES_W : rowol_pkg::POS_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	logic [rowol_pkg::HANDLE_W-1:0] mem_handle [DEPTH];
	logic [rowol_pkg::BYTES_W-1:0]  mem_size   [DEPTH];

	rowol_pkg::back_st_t state_q, state_d;

	logic [IW-1:0] wr_idx_q, rd_idx_q, addr_q;
	logic          full_q;
	logic [CW-1:0] limit_q, issued_q, checked_q, lim_new, chk_nxt;
	logic [SW-1:0] sum_q, sum_nxt, pos_ext, diff;
	logic [rowol_pkg::POS_W-1:0] pos_q;

	logic [rowol_pkg::HANDLE_W-1:0] rd_handle_s1;
	logic [rowol_pkg::BYTES_W-1:0]  rd_size_s1;
	logic                           rd_vld_s1;

	logic do_add, start_find, rd_en, fin, hit;
	logic [IW-1:0] wr_nxt, rd_nxt;

	rowol_pkg::rsp_t rsp_q;
	logic            rsp_valid_q;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		ring_next = (i == LAST_IDX) ? '0 : i + IW'(1);
	endfunction

	assign wr_nxt  = ring_next(wr_idx_q);
	assign rd_nxt  = ring_next(rd_idx_q);
	assign lim_new = full_q ? CW'(DEPTH) : CW'(wr_idx_q);
	assign chk_nxt = checked_q + CW'(1);
	assign pos_ext = SW'(pos_q);
	assign sum_nxt = sum_q + SW'(rd_size_s1);
	assign diff    = pos_ext - sum_q;
	assign hit     = pos_ext < sum_nxt;

	always_comb begin
		pop        = 1'b0;
		do_add     = 1'b0;
		start_find = 1'b0;
		rd_en      = 1'b0;
		fin        = 1'b0;
		unique case (state_q)
			rowol_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					if (head.op == rowol_pkg::OP_ADD) begin
						do_add = 1'b1;
					end else begin
						start_find = 1'b1;
					end
				end
			end
			rowol_pkg::BK_WALK: begin
				fin   = rd_vld_s1 && (hit || chk_nxt == limit_q);
				rd_en = (issued_q != limit_q) && !fin;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rowol_pkg::BK_IDLE: begin
				if (start_find && lim_new != '0) begin
					state_d = rowol_pkg::BK_WALK;
				end
			end
			rowol_pkg::BK_WALK: begin
				if (fin) begin
					state_d = rowol_pkg::BK_IDLE;
				end
			end
			default: state_d = rowol_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rowol_pkg::BK_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			full_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_vld_s1   <= rd_en;
			rsp_valid_q <= (start_find && lim_new == '0) || fin;
			if (do_add) begin
				wr_idx_q <= wr_nxt;
				if (full_q) begin
					rd_idx_q <= rd_nxt;
				end
				full_q <= (wr_nxt == (full_q ? rd_nxt : rd_idx_q));
			end
		end
	end

	// Record memory: one write port for adds, one registered read port for finds.
	always_ff @(posedge clk) begin
		if (do_add) begin
			mem_handle[wr_idx_q] <= head.handle;
			mem_size[wr_idx_q]   <= head.bytes;
		end
		if (rd_en) begin
			rd_handle_s1 <= mem_handle[addr_q];
			rd_size_s1   <= mem_size[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (start_find) begin
			pos_q     <= head.pos;
			limit_q   <= lim_new;
			addr_q    <= rd_idx_q;
			issued_q  <= '0;
			checked_q <= '0;
			sum_q     <= '0;
		end else begin
			if (rd_en) begin
				addr_q   <= ring_next(addr_q);
				issued_q <= issued_q + CW'(1);
			end
			if (state_q == rowol_pkg::BK_WALK && rd_vld_s1) begin
				checked_q <= chk_nxt;
				sum_q     <= sum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin && hit) begin
			rsp_q.found       <= 1'b1;
			rsp_q.hit_handle  <= rd_handle_s1;
			rsp_q.hit_bytes   <= rd_size_s1;
			rsp_q.byte_within <= diff[rowol_pkg::BYTES_W-1:0];
		end else if (fin || start_find) begin
			rsp_q <= '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- design/ring_of_writes_offset_lookup.sv -----
// ----------------------------------------------------------------------------
// ring_of_writes_offset_lookup: ring of write records with offset lookup
// Stores DEPTH (handle, size) records, overwriting the oldest when full, and
// maps a character offset to the record that holds it.
// ----------------------------------------------------------------------------
//
//   Channel    Handshake            Payload   Direction
//   request    start & !busy        req       in
//   response   rsp_valid (1 cycle)  rsp       out
//
// An add transaction passes through the intake register and the command queue
// and is written to the record memory when it reaches the head of the queue
// while the back end is idle; it gives no response. A find transaction walks
// the stored records at one per cycle from the single registered read port of
// the record memory and visits at most DEPTH records before it responds. An
// empty ring answers without a walk. Commands execute strictly in order.
// Reset clears the ring indices, the full flag and all handshake state; the
// record memory holds no reset value and is only read where written.
// busy rises when the intake register and the two-entry queue are all
// occupied; the response side cannot stall, so each response is shown for
// exactly one cycle.
// ----------------------------------------------------------------------------
module ring_of_writes_offset_lookup #(
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rowol_pkg::req_t req,
	output logic            busy,
	output logic            rsp_valid,
	output rowol_pkg::rsp_t rsp
);

	// Control status between the queue and both ends.
	rowol_pkg::q_stat_t q_stat;
	rowol_pkg::cmd_t    push_cmd;
	rowol_pkg::cmd_t    head;
	logic               push;
	logic               pop;

	// The front end registers and decodes each request transaction.
	rowol_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// The queue lets intake keep accepting while a long find is walking.
	rowol_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// The back end owns the record memory and produces find responses.
	rowol_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// Intake can only be blocked by a full queue.
	a_busy_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_stat.full)
		else $error("busy asserted while the command queue has room");

	// The queue can never report full and empty together.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("command queue reports full and empty at once");

	// A miss carries all-zero payload fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |->
		(rsp.hit_handle == '0 && rsp.hit_bytes == '0 && rsp.byte_within == '0))
		else $error("not-found response with nonzero payload");

	// A hit always lies inside the record it names.
	a_hit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> (rsp.byte_within < rsp.hit_bytes))
		else $error("hit offset lies outside its record");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the write-record ring with offset lookup
// Drives add and find transactions through the start/busy request port. A
// model of the ring in the testbench predicts every find response, and each
// response strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int HANDLE_W     = rowol_pkg::HANDLE_W;
	localparam int BYTES_W      = rowol_pkg::BYTES_W;
	localparam int POS_W        = rowol_pkg::POS_W;
	localparam int DEPTH        = 16;
	localparam int LIMIT_CYCLES = 200000;
	// A find visits at most DEPTH records before it answers.
	localparam int SETTLE_CYCLES = DEPTH + 8;

	logic            clk;
	logic            arst_n;
	logic            start;
	rowol_pkg::req_t req;
	logic            busy;
	logic            rsp_valid;
	rowol_pkg::rsp_t rsp;

	ring_of_writes_offset_lookup #(
		.DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	// ------------------------------------------------------------------------
	// Shadow copy of the ring. It is updated at the clock edge where a
	// transaction is accepted, so it always reflects the order in which the
	// block executes commands.
	// ------------------------------------------------------------------------
	logic [HANDLE_W-1:0] ring_handle [DEPTH];
	logic [BYTES_W-1:0]  ring_size   [DEPTH];
	int unsigned         wr_ptr;
	int unsigned         rd_ptr;
	bit                  ring_is_full;

	// Find responses that the block still owes, oldest first.
	rowol_pkg::rsp_t pending_lookups [$];

	int unsigned error_count;
	int unsigned cycle_count;
	// Chance, in percent, that the sender sits idle for a given cycle.
	int unsigned idle_pct;

	// Number of records currently stored, oldest at rd_ptr.
	function automatic int unsigned stored_count();
		return ring_is_full ? DEPTH : wr_ptr;
	endfunction

	// Sum of the sizes of the k oldest records.
	function automatic int unsigned prefix_bytes(int unsigned k);
		int unsigned acc;
		acc = 0;
		for (int unsigned n = 0; n < k; n++)
			acc += ring_size[(rd_ptr + n) % DEPTH];
		return acc;
	endfunction

	// Store a record. A full ring drops its oldest record and stays full.
	function automatic void store_record(logic [HANDLE_W-1:0] h, logic [BYTES_W-1:0] b);
		if (ring_is_full)
			rd_ptr = (rd_ptr + 1) % DEPTH;
		ring_handle[wr_ptr] = h;
		ring_size[wr_ptr]   = b;
		wr_ptr              = (wr_ptr + 1) % DEPTH;
		ring_is_full        = (wr_ptr == rd_ptr);
	endfunction

	// Walk from oldest to newest, summing sizes, until the offset falls inside
	// a record. Records of size zero can never hold it and are passed over.
	function automatic rowol_pkg::rsp_t locate_offset(logic [POS_W-1:0] pos);
		rowol_pkg::rsp_t hit;
		int unsigned     acc;
		int unsigned     idx;
		hit = '0;
		acc = 0;
		idx = rd_ptr;
		for (int unsigned n = 0; n < stored_count(); n++) begin
			if (pos < acc + ring_size[idx]) begin
				hit.found       = 1'b1;
				hit.hit_handle  = ring_handle[idx];
				hit.hit_bytes   = ring_size[idx];
				hit.byte_within = BYTES_W'(pos - acc);
				return hit;
			end
			acc += ring_size[idx];
			idx = (idx + 1) % DEPTH;
		end
		return hit;
	endfunction

	// ------------------------------------------------------------------------
	// Clock, reset and the run limit.
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Response checker. Outputs are read right after the edge, before the
	// block's own updates land, so they hold what the edge accepted. Every
	// strobe must match the oldest outstanding prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rowol_pkg::rsp_t want;
		if (arst_n && rsp_valid) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: response with nothing expected: found=%0b handle=%h bytes=%h within=%h",
					$time, rsp.found, rsp.hit_handle, rsp.hit_bytes, rsp.byte_within);
				error_count++;
			end else begin
				want = pending_lookups.pop_front();
				if (rsp.found !== want.found) begin
					$display("%0t: found mismatch: expected %0b, actual %0b",
						$time, want.found, rsp.found);
					error_count++;
				end
				if (rsp.hit_handle !== want.hit_handle) begin
					$display("%0t: hit_handle mismatch: expected %h, actual %h",
						$time, want.hit_handle, rsp.hit_handle);
					error_count++;
				end
				if (rsp.hit_bytes !== want.hit_bytes) begin
					$display("%0t: hit_bytes mismatch: expected %h, actual %h",
						$time, want.hit_bytes, rsp.hit_bytes);
					error_count++;
				end
				if (rsp.byte_within !== want.byte_within) begin
					$display("%0t: byte_within mismatch: expected %h, actual %h",
						$time, want.byte_within, rsp.byte_within);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender. start is raised with the payload and left high; the transaction
	// is taken at the first edge where busy is low. The shadow ring is
	// updated at that same edge. start is not lowered here, so a following
	// transaction keeps it high without a second assignment in one step.
	// ------------------------------------------------------------------------
	task automatic send_item(rowol_pkg::req_t item);
		start <= 1'b1;
		req   <= item;
		do
			@(posedge clk);
		while (busy);
		if (rowol_pkg::op_t'(item.req_type) == rowol_pkg::OP_ADD)
			store_record(item.entry_handle, item.entry_bytes);
		else
			pending_lookups.push_back(locate_offset(item.char_position));
	endtask

	// Idle cycles before the next transaction, drawn cycle by cycle.
	task automatic sender_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold the sender off until every owed response has arrived, then give
	// any trailing add time to drain out of the queue.
	task automatic drain_all();
		start <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_record(logic [HANDLE_W-1:0] h, logic [BYTES_W-1:0] b);
		rowol_pkg::req_t item;
		item               = '0;
		item.req_type      = rowol_pkg::OP_ADD;
		item.entry_handle  = h;
		item.entry_bytes   = b;
		item.char_position = POS_W'($urandom());
		sender_gap();
		send_item(item);
	endtask

	task automatic find_offset(logic [POS_W-1:0] pos);
		rowol_pkg::req_t item;
		item               = '0;
		item.req_type      = rowol_pkg::OP_FIND;
		item.entry_handle  = $urandom();
		item.entry_bytes   = BYTES_W'($urandom());
		item.char_position = pos;
		sender_gap();
		send_item(item);
	endtask

	// Sizes lean small so that finds walk many records; zero sizes and the
	// largest values show up too.
	function automatic logic [BYTES_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12)
			return '0;
		else if (r < 50)
			return BYTES_W'($urandom_range(1, 16));
		else if (r < 80)
			return BYTES_W'($urandom_range(17, 4096));
		else if (r < 85)
			return '1;
		return BYTES_W'($urandom());
	endfunction

	// Offsets mostly land inside the stored data, some exactly on record
	// edges or just past the end, the rest anywhere in the field.
	function automatic logic [POS_W-1:0] pick_offset();
		int unsigned r;
		int unsigned total;
		int unsigned edge_sum;
		r     = $urandom_range(99);
		total = prefix_bytes(stored_count());
		if (total == 0 || r < 20)
			return POS_W'($urandom());
		if (r < 45) begin
			edge_sum = prefix_bytes($urandom_range(stored_count()));
			if (edge_sum > 0 && $urandom_range(1))
				edge_sum--;
			return POS_W'(edge_sum);
		end
		return POS_W'($urandom_range(total - 1));
	endfunction

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Before any add the ring is empty, so every find must miss.
	task automatic test_empty_ring();
		idle_pct = 0;
		find_offset('0);
		find_offset('1);
	endtask

	// Field extremes, a zero-size record that the walk must skip, and finds
	// on both sides of the inner record edge and beyond the stored total.
	task automatic test_field_extremes();
		idle_pct = 0;
		add_record('0, '0);
		add_record('1, '1);
		add_record(32'ha5a5_5a5a, 16'd1);
		find_offset('0);
		find_offset(POS_W'(16'hfffe));
		find_offset(POS_W'(16'hffff));
		find_offset(POS_W'(17'h10000));
		find_offset('1);
	endtask

	// Enough adds to fill the ring and overwrite its oldest records, then
	// finds at the start and just past the end of the data that remains.
	task automatic test_ring_overwrite();
		idle_pct = 0;
		for (int n = 0; n < DEPTH - 2; n++)
			add_record($urandom(), BYTES_W'($urandom_range(1, 9)));
		find_offset('0);
		find_offset(POS_W'(prefix_bytes(DEPTH)));
	endtask

	// Random mix of adds and finds with the sender idle at the given rate.
	task automatic test_random_traffic(int unsigned count, int unsigned pct);
		idle_pct = pct;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(99) < 35)
				add_record($urandom(), pick_size());
			else
				find_offset(pick_offset());
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence of tests. The response side cannot be held off, so the
	// receiver-side stall phases reduce to sender idling alone.
	// ------------------------------------------------------------------------
	initial begin
		error_count = 0;
		cycle_count = 0;
		idle_pct    = 0;
		wr_ptr       = 0;
		rd_ptr       = 0;
		ring_is_full = 1'b0;
		for (int n = 0; n < DEPTH; n++) begin
			ring_handle[n] = '0;
			ring_size[n]   = '0;
		end

		@(posedge arst_n);
		@(posedge clk);

		test_empty_ring();
		test_field_extremes();
		drain_all();
		test_ring_overwrite();
		drain_all();

		test_random_traffic(300, 0);
		drain_all();
		test_random_traffic(300, 65);
		drain_all();
		test_random_traffic(300, 17);

		drain_all();
		if (error_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/rowol_pkg.sv
design/rowol_front.sv
design/rowol_cmd_queue.sv
design/rowol_back.sv
design/ring_of_writes_offset_lookup.sv
tb/tb_top.sv
